// ===== rtl/laplacian_edge_filter_3x3_luma_assert.svh =====
// ----------------------------------------------------------------------------
// Laplacian edge filter assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_FILTER_3X3_LUMA_ASSERT_SVH
`define LAPLACIAN_EDGE_FILTER_3X3_LUMA_ASSERT_SVH

`ifndef SYNTH
// condition holds at every clock edge outside reset
`define LEF_ASSERT(label, clock, reset, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (expr)) \
    else $error("laplacian filter check failed");
// consequent holds in the cycle after the antecedent
`define LEF_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("laplacian filter check failed");
`else
`define LEF_ASSERT(label, clock, reset, expr)
`define LEF_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

// ===== rtl/lef_pkg.sv =====
// ----------------------------------------------------------------------------
// Laplacian edge filter package
// Shared widths, codes, the decision struct and the luma conversion.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int PIX_W      = 24;
  localparam int LUMA_W     = 8;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  // reset frame size before clamping to the build limits
  localparam int WIDTH_RESET  = 800;
  localparam int HEIGHT_RESET = 600;
  localparam int DIM_MIN      = 3;

  // luma weights, sum is 256
  localparam logic [7:0] LUMA_R_COEF = 8'd77;
  localparam logic [7:0] LUMA_G_COEF = 8'd150;
  localparam logic [7:0] LUMA_B_COEF = 8'd29;

  localparam logic [LUMA_W-1:0] LUMA_MAX = 8'hff;

  // kind of an input beat
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } lef_reg_t;

  // per-beat decision taken at input
  typedef struct packed {
    logic emit;
    logic border;
    logic eof;
  } lef_dec_t;

  function automatic logic [LUMA_W-1:0] lef_luma(input logic [PIX_W-1:0] rgb);
    logic [15:0] r_term;
    logic [15:0] g_term;
    logic [15:0] b_term;
    logic [15:0] sum;
    r_term = 16'(rgb[23:16]) * 16'(LUMA_R_COEF);
    g_term = 16'(rgb[15:8])  * 16'(LUMA_G_COEF);
    b_term = 16'(rgb[7:0])   * 16'(LUMA_B_COEF);
    sum    = r_term + g_term + b_term;
    return sum[15:8];
  endfunction

endpackage

// ===== rtl/lef_ctrl.sv =====
// ----------------------------------------------------------------------------
// Laplacian edge filter position control
// Frame size registers, input and output raster counters and the pending
// count; decides per beat whether a result is produced and its border flags.
// ----------------------------------------------------------------------------
module lef_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               accept,
  input  logic                               op,
  output logic [$clog2(MAX_WIDTH)-1:0]       col,
  output lef_pkg::lef_dec_t                  dec
);
  import lef_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);
  localparam int WIDTH_INIT  = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;
  localparam int HEIGHT_INIT = (MAX_HEIGHT < HEIGHT_RESET) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [WID_W-1:0]  width;
  logic [HGT_W-1:0]  height;
  logic [COL_W-1:0]  in_col, in_col_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [COL_W-1:0]  out_col, out_col_next;
  logic [ROW_W-1:0]  out_row, out_row_next;
  logic [PEND_W-1:0] pend, pend_next;
  logic [WID_W-1:0]  width_m1;
  logic [HGT_W-1:0]  height_m1;
  logic              in_col_last, in_row_last, out_col_last, out_row_last;
  logic              pend_full, at_start, emit;

  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < DIM_MIN) return WID_W'(DIM_MIN);
    if (vi > MAX_WIDTH) return WID_W'(MAX_WIDTH);
    return WID_W'(vi);
  endfunction

  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
    int vi;
    vi = int'(v);
    if (vi < DIM_MIN) return HGT_W'(DIM_MIN);
    if (vi > MAX_HEIGHT) return HGT_W'(MAX_HEIGHT);
    return HGT_W'(vi);
  endfunction

  // position compares
  assign width_m1     = width - WID_W'(1);
  assign height_m1    = height - HGT_W'(1);
  assign in_col_last  = (WID_W'(in_col) == width_m1);
  assign in_row_last  = (HGT_W'(in_row) == height_m1);
  assign out_col_last = (WID_W'(out_col) == width_m1);
  assign out_row_last = (HGT_W'(out_row) == height_m1);
  assign pend_full    = (pend == PEND_W'(width) + PEND_W'(1));
  assign at_start     = (in_col == '0) && (in_row == '0);

  // result decision for the beat at the input
  always_comb begin
    if (op == OP_DRAIN) begin
      emit = at_start && (pend != '0);
    end else begin
      emit = pend_full;
    end
    dec.emit   = emit;
    dec.border = (out_row == '0) || out_row_last || (out_col == '0) || out_col_last;
    dec.eof    = out_row_last && out_col_last;
  end

  assign col = in_col;

  // counter advance
  always_comb begin
    in_col_next  = in_col;
    in_row_next  = in_row;
    out_col_next = out_col;
    out_row_next = out_row;
    pend_next    = pend;
    if (op == OP_PIXEL) begin
      in_col_next = in_col_last ? '0 : in_col + COL_W'(1);
      if (in_col_last) begin
        in_row_next = in_row_last ? '0 : in_row + ROW_W'(1);
      end
      if (!emit) begin
        pend_next = pend + PEND_W'(1);
      end
    end else if (emit) begin
      pend_next = pend - PEND_W'(1);
    end
    if (emit) begin
      out_col_next = out_col_last ? '0 : out_col + COL_W'(1);
      if (out_col_last) begin
        out_row_next = out_row_last ? '0 : out_row + ROW_W'(1);
      end
    end
  end

  // frame size registers and counters; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      width   <= WID_W'(WIDTH_INIT);
      height  <= HGT_W'(HEIGHT_INIT);
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pend    <= '0;
    end else if (cfg_we) begin
      case (lef_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width  <= clamp_width(cfg_data);
        REG_IMAGE_HEIGHT: height <= clamp_height(cfg_data);
        default: ;
      endcase
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
      pend    <= '0;
    end else if (accept) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
      pend    <= pend_next;
    end
  end

endmodule

// ===== rtl/lef_line_buf.sv =====
// ----------------------------------------------------------------------------
// Laplacian edge filter line store
// Two luma lines side by side in one word per column: upper line in the
// high byte, middle line in the low byte. One read and one write port.
// ----------------------------------------------------------------------------
module lef_line_buf #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  output logic [2*lef_pkg::LUMA_W-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  logic [2*lef_pkg::LUMA_W-1:0]  wr_data
);
  import lef_pkg::*;

  logic [2*LUMA_W-1:0] mem [MAX_WIDTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/lef_window.sv =====
// ----------------------------------------------------------------------------
// Laplacian edge filter window
// 3x3 luma window that shifts in one column per pixel, and the clamped
// Laplacian of the window as it stands after the shift.
// ----------------------------------------------------------------------------
module lef_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear,
  input  logic                        shift,
  input  logic [lef_pkg::LUMA_W-1:0]  top,
  input  logic [lef_pkg::LUMA_W-1:0]  mid,
  input  logic [lef_pkg::LUMA_W-1:0]  bot,
  output logic [lef_pkg::LUMA_W-1:0]  lap
);
  import lef_pkg::*;

  logic [LUMA_W-1:0]        win      [3][3];
  logic [LUMA_W-1:0]        win_next [3][3];
  logic [LUMA_W+2:0]        nb_sum;
  logic signed [LUMA_W+3:0] diff;

  // next window: shift left and load the new right column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_next[i][j] = win[i][j];
      end
    end
    if (shift) begin
      for (int i = 0; i < 3; i++) begin
        win_next[i][0] = win[i][1];
        win_next[i][1] = win[i][2];
      end
      win_next[0][2] = top;
      win_next[1][2] = mid;
      win_next[2][2] = bot;
    end
  end

  // eight times centre minus the neighbours, clamped to a byte
  always_comb begin
    nb_sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i != 1 || j != 1) begin
          nb_sum = nb_sum + (LUMA_W+3)'(win_next[i][j]);
        end
      end
    end
    diff = $signed({1'b0, win_next[1][1], 3'b000}) - $signed({1'b0, nb_sum});
    if (diff < 0) begin
      lap = '0;
    end else if (diff > $signed((LUMA_W+4)'(LUMA_MAX))) begin
      lap = LUMA_MAX;
    end else begin
      lap = diff[LUMA_W-1:0];
    end
  end

  // window registers
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= win_next[i][j];
        end
      end
    end
  end

endmodule

// ===== rtl/laplacian_edge_filter_3x3_luma.sv =====
// ----------------------------------------------------------------------------
// Laplacian edge filter 3x3 on luma
// Converts RGB pixels to luma, filters with a 3x3 Laplacian and returns the
// clamped edge strength as a grey RGB pixel.
// ----------------------------------------------------------------------------
// Accepts one beat per clock while no result is blocked at the output, pixels
// or drain ticks, in raster order. For a pixel beat the input stage registers
// its luma and reads the line store, and the filter stage shifts the window,
// writes the line store back and computes the Laplacian into the output
// register. Results trail the input by one line plus one pixel; the last
// width + 1 results of a frame come out on drain beats sent after the frame's
// last pixel. Border rows and columns give zero and the last result of a
// frame carries tlast. Writing either size register restarts the frame; the
// line store needs no clearing after reset, as unwritten entries only feed
// border positions.
module laplacian_edge_filter_3x3_luma #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [lef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lef_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [lef_pkg::PIX_W-1:0]          s_tdata,   // pixel_rgb [23:0]
  input  logic                               s_tuser,   // operation [0]
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [lef_pkg::PIX_W-1:0]          m_tdata,   // gray_rgb [23:0]
  output logic                               m_tlast
);
  import lef_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  logic              accept;
  logic [COL_W-1:0]  in_col;
  lef_dec_t          dec;

  logic              s1_valid;
  logic              s1_pixel;
  logic [COL_W-1:0]  s1_col;
  logic [LUMA_W-1:0] s1_luma;
  lef_dec_t          s1_dec;
  logic              s1_adv;

  logic [2*LUMA_W-1:0] lines_rd;
  logic                shift;
  logic [LUMA_W-1:0]   lap;
  logic [LUMA_W-1:0]   gray;

  logic              out_valid;
  logic [PIX_W-1:0]  out_data;
  logic              out_last;

  // handshake: the filter stage moves unless its result is blocked
  assign s1_adv   = s1_valid && (!s1_dec.emit || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;
  assign shift    = s1_adv && s1_pixel;

  // position control
  lef_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (s_tuser),
    .col       (in_col),
    .dec       (dec)
  );

  // line store: read at input, written back from the filter stage
  lef_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept && (s_tuser == OP_PIXEL)),
    .rd_addr (in_col),
    .rd_data (lines_rd),
    .wr_en   (shift),
    .wr_addr (s1_col),
    .wr_data ({lines_rd[LUMA_W-1:0], s1_luma})
  );

  // window and Laplacian
  lef_window u_window (
    .clk   (clk),
    .rst   (rst),
    .clear (cfg_we),
    .shift (shift),
    .top   (lines_rd[2*LUMA_W-1:LUMA_W]),
    .mid   (lines_rd[LUMA_W-1:0]),
    .bot   (s1_luma),
    .lap   (lap)
  );

  assign gray = s1_dec.border ? '0 : lap;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel <= (s_tuser == OP_PIXEL);
      s1_col   <= in_col;
      s1_luma  <= lef_luma(s_tdata);
      s1_dec   <= dec;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_dec.emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_dec.emit) begin
      out_data <= {gray, gray, gray};
      out_last <= s1_dec.eof;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tlast  = out_last;

  // checks
  `include "laplacian_edge_filter_3x3_luma_assert.svh"

  `LEF_ASSERT_NEXT(a_blocked_result_held, clk, rst, s1_valid && s1_dec.emit && out_valid && !m_tready, s1_valid)
  `LEF_ASSERT(a_drain_is_border, clk, rst, !(s1_valid && !s1_pixel && s1_dec.emit) || s1_dec.border)
  `LEF_ASSERT(a_eof_is_border, clk, rst, !(s1_valid && s1_dec.eof) || s1_dec.border)

endmodule
